/* rtl/sscre_pkg.sv */
package sscre_pkg;

	localparam int MAX_TRANSFER_BYTES_DEF = 4096;
	localparam int LIMIT_W = 17;
	localparam int LEN_IN_W = 13;
	localparam int TX_BYTES = 6;
	localparam int BATCH_CNT_W = 3;

	localparam logic [LIMIT_W-1:0] RESP_LIMIT_RESET = 17'd256;
	localparam logic [LIMIT_W-1:0] BLOCK_LIMIT_RESET = 17'd65536;

	// configuration register indexes
	localparam logic REG_RESP_LIMIT = 1'b0;
	localparam logic REG_BLOCK_LIMIT = 1'b1;

	localparam logic [7:0] CMD_LIMIT = 8'd64;
	localparam logic [7:0] CMD_GO_IDLE = 8'd0;
	localparam logic [7:0] CMD_IF_COND = 8'd8;
	localparam logic [7:0] CMD_START_BITS = 8'h40;
	localparam logic [7:0] CRC_CMD0 = 8'h95;
	localparam logic [7:0] CRC_CMD8 = 8'h87;
	localparam logic [7:0] CRC_OTHER = 8'h01;
	localparam logic [7:0] TOKEN_START = 8'hFE;
	localparam logic [7:0] IDLE_BYTE = 8'hFF;

	localparam logic ACT_COMMAND = 1'b0;
	localparam logic ACT_RX_BYTE = 1'b1;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_R1,
		PH_RESP,
		PH_TOKEN,
		PH_PAYLOAD,
		PH_CRC,
		PH_TRAIL
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_ILLEGAL = 3'd1,
		ST_LINK    = 3'd2,
		ST_TIMEOUT = 3'd3,
		ST_RESP    = 3'd4,
		ST_TOKEN   = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		KIND_TX     = 2'd0,
		KIND_DATA   = 2'd1,
		KIND_STATUS = 2'd2
	} kind_t;

	typedef struct packed {
		logic                action;
		logic [7:0]          cmd_index;
		logic [31:0]         argument;
		logic                block_read;
		logic [LEN_IN_W-1:0] length;
		logic [7:0]          rx_byte;
		logic                rx_error;
	} item_t;

	// results produced by one transaction, first one in bytes[0]
	typedef struct packed {
		logic [BATCH_CNT_W-1:0]    count;
		kind_t                     kind;
		status_t                   status;
		logic [TX_BYTES-1:0][7:0]  bytes;
	} batch_t;

endpackage

/* rtl/sd_spi_command_response_engine_top.sv */
// A transaction is held in the input register until the output serializer is free; its
// results are then loaded into the output register and presented from there.
// Throughput: one received byte per cycle while the output is not stalled; a command occupies
// the output register until all six transmit bytes have left, set by the single-result output port.
// Reset: arst_n clears the parser to idle and sets the poll limits to 256 and 65536.
module sd_spi_command_response_engine_top #(
	parameter int MAX_TRANSFER_BYTES = sscre_pkg::MAX_TRANSFER_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [sscre_pkg::LIMIT_W-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          action,
	input  logic [7:0]                    cmd_index,
	input  logic [31:0]                   argument,
	input  logic                          block_read,
	input  logic [sscre_pkg::LEN_IN_W-1:0] length,
	input  logic [7:0]                    rx_byte,
	input  logic                          rx_error,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    out_kind,
	output logic [7:0]                    out_byte,
	output logic [2:0]                    status,
	output logic                          last
);
	import sscre_pkg::*;

	logic               valid_s1;
	item_t              item_s1;
	logic [LIMIT_W-1:0] resp_limit_q;
	logic [LIMIT_W-1:0] block_limit_q;
	logic               ser_free;
	logic               take;
	batch_t             batch;

	assign take     = valid_s1 && ser_free;
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resp_limit_q  <= RESP_LIMIT_RESET;
			block_limit_q <= BLOCK_LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RESP_LIMIT:  resp_limit_q  <= cfg_data;
				REG_BLOCK_LIMIT: block_limit_q <= cfg_data;
				default:         resp_limit_q  <= resp_limit_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.action     <= action;
			item_s1.cmd_index  <= cmd_index;
			item_s1.argument   <= argument;
			item_s1.block_read <= block_read;
			item_s1.length     <= length;
			item_s1.rx_byte    <= rx_byte;
			item_s1.rx_error   <= rx_error;
		end
	end

	sscre_parser #(
		.MAX_TRANSFER_BYTES(MAX_TRANSFER_BYTES)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.item       (item_s1),
		.resp_limit (resp_limit_q),
		.block_limit(block_limit_q),
		.batch      (batch)
	);

	sscre_out_ser u_out_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (take),
		.batch    (batch),
		.free     (ser_free),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_kind (out_kind),
		.out_byte (out_byte),
		.status   (status),
		.last     (last)
	);

	// a completion status always ends its transaction's run
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == KIND_STATUS |-> last)
		else $error("status result not marked last");

	// non-status results carry a zero status
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind != KIND_STATUS |-> status == ST_OK)
		else $error("nonzero status on byte result");

	// a run that is not finished keeps the output valid
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid)
		else $error("result run broken off");

	// the input is always ready while the input register is empty
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stalled while input register empty");

endmodule

/* rtl/sscre_parser.sv */
module sscre_parser #(
	parameter int MAX_TRANSFER_BYTES = sscre_pkg::MAX_TRANSFER_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          take,
	input  sscre_pkg::item_t              item,
	input  logic [sscre_pkg::LIMIT_W-1:0] resp_limit,
	input  logic [sscre_pkg::LIMIT_W-1:0] block_limit,
	output sscre_pkg::batch_t             batch
);
	import sscre_pkg::*;

	localparam int LEN_W = $clog2(MAX_TRANSFER_BYTES + 1);
	localparam int CNT_W = (LEN_W < 2) ? 2 : LEN_W;

	phase_t             phase_q, phase_d;
	logic [LIMIT_W-1:0] poll_q, poll_d;
	logic [CNT_W-1:0]   bcnt_q, bcnt_d;
	logic               mode_blk_q, mode_blk_d;
	logic [CNT_W-1:0]   want_q, want_d;
	status_t            pend_q, pend_d;

	logic [LIMIT_W-1:0] poll_inc;
	logic [LIMIT_W-1:0] r1_limit;
	logic [CNT_W-1:0]   bcnt_inc;
	logic               cmd_bad;
	logic [7:0]         crc_byte;

	assign poll_inc = poll_q + LIMIT_W'(1);
	assign bcnt_inc = bcnt_q + CNT_W'(1);
	assign r1_limit = mode_blk_q ? block_limit : resp_limit;
	assign cmd_bad  = (item.cmd_index >= CMD_LIMIT);
	assign crc_byte = (item.cmd_index == CMD_GO_IDLE) ? CRC_CMD0 :
		(item.cmd_index == CMD_IF_COND) ? CRC_CMD8 : CRC_OTHER;

	// next state
	always_comb begin
		phase_d    = phase_q;
		poll_d     = poll_q;
		bcnt_d     = bcnt_q;
		mode_blk_d = mode_blk_q;
		want_d     = want_q;
		pend_d     = pend_q;
		if (item.action == ACT_COMMAND) begin
			if (cmd_bad) begin
				phase_d = PH_IDLE;
			end else begin
				phase_d    = PH_R1;
				poll_d     = '0;
				bcnt_d     = '0;
				mode_blk_d = item.block_read;
				pend_d     = ST_OK;
				if (32'(item.length) > 32'(MAX_TRANSFER_BYTES))
					want_d = CNT_W'(MAX_TRANSFER_BYTES);
				else
					want_d = CNT_W'(item.length);
			end
		end else begin
			unique case (phase_q)
				PH_R1: begin
					poll_d = poll_inc;
					if (item.rx_error) begin
						phase_d = PH_TRAIL;
						pend_d  = ST_LINK;
					end else if (poll_inc >= r1_limit) begin
						phase_d = PH_TRAIL;
						pend_d  = ST_TIMEOUT;
					end else if (!item.rx_byte[7]) begin
						if (mode_blk_q) begin
							if (item.rx_byte == 8'h00) begin
								phase_d = PH_TOKEN;
								poll_d  = '0;
							end else begin
								phase_d = PH_TRAIL;
								pend_d  = ST_RESP;
							end
						end else if (item.rx_byte == 8'h00 || item.rx_byte == 8'h01) begin
							if (want_q > CNT_W'(1)) begin
								bcnt_d  = CNT_W'(1);
								phase_d = PH_RESP;
							end else begin
								phase_d = PH_TRAIL;
								pend_d  = ST_OK;
							end
						end else begin
							phase_d = PH_TRAIL;
							pend_d  = ST_RESP;
						end
					end
				end
				PH_RESP: begin
					bcnt_d = bcnt_inc;
					if (bcnt_inc >= want_q) begin
						phase_d = PH_TRAIL;
						pend_d  = ST_OK;
					end
				end
				PH_TOKEN: begin
					poll_d = poll_inc;
					if (item.rx_error) begin
						phase_d = PH_TRAIL;
						pend_d  = ST_LINK;
					end else if (poll_inc >= block_limit) begin
						phase_d = PH_TRAIL;
						pend_d  = ST_TIMEOUT;
					end else if (item.rx_byte == TOKEN_START) begin
						bcnt_d  = '0;
						phase_d = (want_q == '0) ? PH_CRC : PH_PAYLOAD;
					end else if (item.rx_byte != IDLE_BYTE) begin
						phase_d = PH_TRAIL;
						pend_d  = ST_TOKEN;
					end
				end
				PH_PAYLOAD: begin
					bcnt_d = bcnt_inc;
					if (bcnt_inc >= want_q) begin
						bcnt_d  = '0;
						phase_d = PH_CRC;
					end
				end
				PH_CRC: begin
					bcnt_d = bcnt_inc;
					if (bcnt_inc >= CNT_W'(2)) begin
						phase_d = PH_TRAIL;
						pend_d  = ST_OK;
					end
				end
				PH_TRAIL: phase_d = PH_IDLE;
				default:  phase_d = PH_IDLE;
			endcase
		end
	end

	// results of this transaction
	always_comb begin
		batch        = '0;
		batch.kind   = KIND_TX;
		batch.status = ST_OK;
		if (item.action == ACT_COMMAND) begin
			if (cmd_bad) begin
				batch.count  = BATCH_CNT_W'(1);
				batch.kind   = KIND_STATUS;
				batch.status = ST_ILLEGAL;
			end else begin
				batch.count    = BATCH_CNT_W'(TX_BYTES);
				batch.bytes[0] = item.cmd_index | CMD_START_BITS;
				batch.bytes[1] = item.argument[31:24];
				batch.bytes[2] = item.argument[23:16];
				batch.bytes[3] = item.argument[15:8];
				batch.bytes[4] = item.argument[7:0];
				batch.bytes[5] = crc_byte;
			end
		end else begin
			unique case (phase_q)
				PH_R1: begin
					// R1 goes out in response mode even when rejected
					if (!item.rx_error && !(poll_inc >= r1_limit) && !item.rx_byte[7]
							&& !mode_blk_q) begin
						batch.count    = BATCH_CNT_W'(1);
						batch.kind     = KIND_DATA;
						batch.bytes[0] = item.rx_byte;
					end
				end
				PH_RESP, PH_PAYLOAD: begin
					batch.count    = BATCH_CNT_W'(1);
					batch.kind     = KIND_DATA;
					batch.bytes[0] = item.rx_byte;
				end
				PH_TRAIL: begin
					batch.count  = BATCH_CNT_W'(1);
					batch.kind   = KIND_STATUS;
					batch.status = pend_q;
				end
				default: batch.count = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			poll_q     <= '0;
			bcnt_q     <= '0;
			mode_blk_q <= 1'b0;
			want_q     <= '0;
			pend_q     <= ST_OK;
		end else if (take) begin
			phase_q    <= phase_d;
			poll_q     <= poll_d;
			bcnt_q     <= bcnt_d;
			mode_blk_q <= mode_blk_d;
			want_q     <= want_d;
			pend_q     <= pend_d;
		end
	end

endmodule

/* rtl/sscre_out_ser.sv */
module sscre_out_ser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  sscre_pkg::batch_t   batch,
	output logic                free,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          out_kind,
	output logic [7:0]          out_byte,
	output logic [2:0]          status,
	output logic                last
);
	import sscre_pkg::*;

	logic                     busy_q;
	logic [BATCH_CNT_W-1:0]   cnt_q;
	kind_t                    kind_q;
	status_t                  status_q;
	logic [TX_BYTES-1:0][7:0] bytes_q;
	logic                     fire;

	assign out_valid = busy_q;
	assign last      = (cnt_q == BATCH_CNT_W'(1));
	assign out_kind  = kind_q;
	assign out_byte  = bytes_q[0];
	assign status    = status_q;
	assign fire      = busy_q && out_ready;
	// free now, or the final result of the batch leaves this cycle
	assign free      = !busy_q || (fire && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (load) begin
			busy_q <= (batch.count != '0);
			cnt_q  <= batch.count;
		end else if (fire) begin
			cnt_q <= cnt_q - BATCH_CNT_W'(1);
			if (last)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q   <= batch.kind;
			status_q <= batch.status;
			bytes_q  <= batch.bytes;
		end else if (fire) begin
			bytes_q <= {8'h00, bytes_q[TX_BYTES-1:1]};
		end
	end

endmodule

/* dv/tb_top.sv */
module tb_top;
	import sscre_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam int PHASE_ITEMS = 24;
	localparam logic [12:0] MAX_LEN = 13'(MAX_TRANSFER_BYTES_DEF);
	localparam logic [7:0] R1_READY = 8'h00;
	localparam logic [7:0] R1_IDLE = 8'h01;
	localparam logic [7:0] CMD_READ_BLOCK = 8'd17;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		status_t    st;
		logic       last;
	} result_t;

	// typed: the row carries its own single expected result
	typedef struct packed {
		logic    typed;
		result_t res;
	} note_t;

	typedef struct packed {
		item_t it;
		note_t note;
	} row_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] resp;
		logic [LIMIT_W-1:0] blk;
	} limits_t;

	localparam note_t NO_NOTE = '0;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = REG_RESP_LIMIT;
	logic [LIMIT_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic action = ACT_COMMAND;
	logic [7:0] cmd_index = '0;
	logic [31:0] argument = '0;
	logic block_read = 1'b0;
	logic [LEN_IN_W-1:0] length = '0;
	logic [7:0] rx_byte = '0;
	logic rx_error = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] out_kind;
	logic [7:0] out_byte;
	logic [2:0] status;
	logic last;

	note_t row_check = '0;
	bit in_idle = 1'b1;
	bit out_idle = 1'b1;
	int mismatches = 0;
	int quiet_cycles = 0;
	int random_items = 0;

	// engine image kept by the predictor
	logic [LIMIT_W-1:0] resp_lim = RESP_LIMIT_RESET;
	logic [LIMIT_W-1:0] blk_lim = BLOCK_LIMIT_RESET;
	phase_t ph = PH_IDLE;
	logic [LIMIT_W-1:0] poll_cnt = '0;
	logic [12:0] byte_cnt = '0;
	logic mode_blk = 1'b0;
	logic [12:0] want_len = '0;
	status_t pend_st = ST_OK;

	result_t step_results[$];
	result_t awaited_results[$];

	sd_spi_command_response_engine_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.cmd_index(cmd_index),
		.argument(argument),
		.block_read(block_read),
		.length(length),
		.rx_byte(rx_byte),
		.rx_error(rx_error),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_kind(out_kind),
		.out_byte(out_byte),
		.status(status),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void queue_result(kind_t k, logic [7:0] d, status_t s);
		result_t r;
		r.kind = k;
		r.data = d;
		r.st = s;
		r.last = 1'b0;
		step_results.push_back(r);
	endfunction

	function automatic void end_transfer(status_t s);
		pend_st = s;
		ph = PH_TRAIL;
	endfunction

	function automatic void predict_engine(item_t it);
		logic [LIMIT_W-1:0] lim;
		logic [7:0] crc;
		result_t tail;
		step_results.delete();
		if (it.action == ACT_COMMAND) begin
			if (it.cmd_index >= CMD_LIMIT) begin
				ph = PH_IDLE;
				queue_result(KIND_STATUS, 8'h00, ST_ILLEGAL);
			end else begin
				if (it.cmd_index == CMD_GO_IDLE)
					crc = CRC_CMD0;
				else if (it.cmd_index == CMD_IF_COND)
					crc = CRC_CMD8;
				else
					crc = CRC_OTHER;
				queue_result(KIND_TX, it.cmd_index | CMD_START_BITS, ST_OK);
				queue_result(KIND_TX, it.argument[31:24], ST_OK);
				queue_result(KIND_TX, it.argument[23:16], ST_OK);
				queue_result(KIND_TX, it.argument[15:8], ST_OK);
				queue_result(KIND_TX, it.argument[7:0], ST_OK);
				queue_result(KIND_TX, crc, ST_OK);
				ph = PH_R1;
				poll_cnt = '0;
				byte_cnt = '0;
				mode_blk = it.block_read;
				want_len = (it.length > MAX_LEN) ? MAX_LEN : it.length;
				pend_st = ST_OK;
			end
		end else begin
			case (ph)
				PH_R1: begin
					lim = mode_blk ? blk_lim : resp_lim;
					poll_cnt = poll_cnt + 17'd1;
					if (it.rx_error)
						end_transfer(ST_LINK);
					else if (poll_cnt >= lim)
						end_transfer(ST_TIMEOUT);
					else if (!it.rx_byte[7]) begin
						if (mode_blk) begin
							if (it.rx_byte == R1_READY) begin
								ph = PH_TOKEN;
								poll_cnt = '0;
							end else
								end_transfer(ST_RESP);
						end else begin
							queue_result(KIND_DATA, it.rx_byte, ST_OK);
							if (it.rx_byte == R1_READY || it.rx_byte == R1_IDLE) begin
								if (want_len > 13'd1) begin
									byte_cnt = 13'd1;
									ph = PH_RESP;
								end else
									end_transfer(ST_OK);
							end else
								end_transfer(ST_RESP);
						end
					end
				end
				PH_RESP: begin
					queue_result(KIND_DATA, it.rx_byte, ST_OK);
					byte_cnt = byte_cnt + 13'd1;
					if (byte_cnt >= want_len)
						end_transfer(ST_OK);
				end
				PH_TOKEN: begin
					poll_cnt = poll_cnt + 17'd1;
					if (it.rx_error)
						end_transfer(ST_LINK);
					else if (poll_cnt >= blk_lim)
						end_transfer(ST_TIMEOUT);
					else if (it.rx_byte == TOKEN_START) begin
						byte_cnt = '0;
						ph = (want_len == '0) ? PH_CRC : PH_PAYLOAD;
					end else if (it.rx_byte != IDLE_BYTE)
						end_transfer(ST_TOKEN);
				end
				PH_PAYLOAD: begin
					queue_result(KIND_DATA, it.rx_byte, ST_OK);
					byte_cnt = byte_cnt + 13'd1;
					if (byte_cnt >= want_len) begin
						byte_cnt = '0;
						ph = PH_CRC;
					end
				end
				PH_CRC: begin
					byte_cnt = byte_cnt + 13'd1;
					if (byte_cnt >= 13'd2)
						end_transfer(ST_OK);
				end
				PH_TRAIL: begin
					queue_result(KIND_STATUS, 8'h00, pend_st);
					ph = PH_IDLE;
				end
				default: begin
					ph = PH_IDLE;
				end
			endcase
		end
		if (step_results.size() > 0) begin
			tail = step_results.pop_back();
			tail.last = 1'b1;
			step_results.push_back(tail);
		end
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0h actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		item_t seen;
		result_t want;
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_index == REG_RESP_LIMIT)
					resp_lim = cfg_data;
				else
					blk_lim = cfg_data;
			end
			if (in_valid && in_ready) begin
				seen = {action, cmd_index, argument, block_read, length, rx_byte, rx_error};
				predict_engine(seen);
				if (row_check.typed)
					awaited_results.push_back(row_check.res);
				else
					foreach (step_results[i])
						awaited_results.push_back(step_results[i]);
			end
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: unexpected result: expected none actual kind %0d byte %0h status %0d last %0b",
						$time, out_kind, out_byte, status, last);
					mismatches++;
				end else begin
					want = awaited_results.pop_front();
					check_field("out_kind", 8'(want.kind), 8'(out_kind));
					check_field("out_byte", want.data, out_byte);
					check_field("status", 8'(want.st), 8'(status));
					check_field("last", 8'(want.last), 8'(last));
				end
			end
		end
	end

	// count cycles with no transaction on any port
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			quiet_cycles <= 0;
		else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		int stall;
		forever begin
			stall = out_idle ? $urandom_range(0, 16) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	function automatic item_t command_item(logic [7:0] idx, logic [31:0] arg, logic blk,
			logic [12:0] len);
		item_t it;
		it = '0;
		it.action = ACT_COMMAND;
		it.cmd_index = idx;
		it.argument = arg;
		it.block_read = blk;
		it.length = len;
		return it;
	endfunction

	function automatic item_t rx_item(logic [7:0] b, logic err);
		item_t it;
		it = '0;
		it.action = ACT_RX_BYTE;
		it.rx_byte = b;
		it.rx_error = err;
		return it;
	endfunction

	// receive byte with the unused fields scrambled
	function automatic item_t random_rx(logic [7:0] b, int err_pct);
		item_t it;
		it = rx_item(b, $urandom_range(0, 99) < err_pct);
		it.cmd_index = 8'($urandom);
		it.argument = $urandom;
		it.block_read = 1'($urandom);
		it.length = 13'($urandom);
		return it;
	endfunction

	function automatic note_t status_note(status_t s);
		note_t n;
		n.typed = 1'b1;
		n.res.kind = KIND_STATUS;
		n.res.data = 8'h00;
		n.res.st = s;
		n.res.last = 1'b1;
		return n;
	endfunction

	task automatic send(input item_t it, input note_t note);
		int gap;
		gap = in_idle ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= it.action;
		cmd_index <= it.cmd_index;
		argument <= it.argument;
		block_read <= it.block_read;
		length <= it.length;
		rx_byte <= it.rx_byte;
		rx_error <= it.rx_error;
		row_check <= note;
		do @(posedge clk); while (!in_ready);
	endtask

	// drop valid, drain expected results, then let the last byte clear the pipeline
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (awaited_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_limits(input limits_t lim);
		cfg_we <= 1'b1;
		cfg_index <= REG_RESP_LIMIT;
		cfg_data <= lim.resp;
		@(posedge clk);
		cfg_index <= REG_BLOCK_LIMIT;
		cfg_data <= lim.blk;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_transfer(input bit full_block);
		item_t seq[$];
		item_t cmd;
		int pick;
		int err_pct;
		int keep;
		logic [12:0] span;
		cmd = random_rx(8'($urandom), 50);
		cmd.action = ACT_COMMAND;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			cmd.cmd_index = CMD_GO_IDLE;
		else if (pick == 1)
			cmd.cmd_index = CMD_IF_COND;
		else if (pick == 2)
			cmd.cmd_index = 8'($urandom_range(64, 255));
		else
			cmd.cmd_index = 8'($urandom_range(0, 63));
		if ($urandom_range(0, 4) == 0)
			cmd.length = 13'($urandom_range(0, 8191));
		else
			cmd.length = 13'($urandom_range(0, 6));
		err_pct = 3;
		if (full_block) begin
			cmd.cmd_index = CMD_READ_BLOCK;
			cmd.block_read = 1'b1;
			cmd.length = 13'h1FFF;
			err_pct = 0;
		end
		seq.push_back(cmd);
		if (cmd.cmd_index >= CMD_LIMIT) begin
			// stray byte with nothing in flight
			if ($urandom_range(0, 1) == 1)
				seq.push_back(random_rx(8'($urandom), err_pct));
			random_items += 1;
		end else begin
			span = (cmd.length > MAX_LEN) ? MAX_LEN : cmd.length;
			repeat ($urandom_range(0, 3))
				seq.push_back(random_rx(8'h80 | 8'($urandom_range(0, 127)), err_pct));
			if (cmd.block_read) begin
				if ($urandom_range(0, 99) < 85)
					seq.push_back(random_rx(R1_READY, err_pct));
				else
					seq.push_back(random_rx(8'($urandom), err_pct));
				repeat ($urandom_range(0, 2))
					seq.push_back(random_rx(IDLE_BYTE, err_pct));
				if ($urandom_range(0, 9) != 0)
					seq.push_back(random_rx(TOKEN_START, err_pct));
				else
					seq.push_back(random_rx(8'($urandom), err_pct));
				repeat (span)
					seq.push_back(random_rx(8'($urandom), err_pct));
				repeat (2)
					seq.push_back(random_rx(8'($urandom), err_pct));
			end else begin
				if ($urandom_range(0, 99) < 85)
					seq.push_back(random_rx(8'($urandom_range(0, 1)), err_pct));
				else
					seq.push_back(random_rx(8'($urandom), err_pct));
				if (span > 13'd1)
					repeat (span - 13'd1)
						seq.push_back(random_rx(8'($urandom), err_pct));
			end
			seq.push_back(random_rx(8'($urandom), err_pct));
			// cut long or unlucky transfers short; the next command abandons them
			if (!full_block && (span > 13'd8 || $urandom_range(0, 9) == 0)) begin
				keep = $urandom_range(1, 5);
				while (seq.size() > keep)
					void'(seq.pop_back());
			end
			random_items += seq.size();
		end
		foreach (seq[i])
			send(seq[i], NO_NOTE);
	endtask

	initial begin
		row_t directed[30];
		limits_t settings[5];
		directed = '{
			'{rx_item(8'h00, 1'b0), NO_NOTE},
			'{command_item(CMD_LIMIT, 32'h0, 1'b0, 13'd1), status_note(ST_ILLEGAL)},
			'{command_item(8'hFF, 32'hFFFF_FFFF, 1'b1, 13'h1FFF), status_note(ST_ILLEGAL)},
			'{command_item(CMD_GO_IDLE, 32'h0, 1'b0, 13'd1), NO_NOTE},
			'{rx_item(IDLE_BYTE, 1'b0), NO_NOTE},
			'{rx_item(R1_IDLE, 1'b0), NO_NOTE},
			'{rx_item(8'hA5, 1'b1), status_note(ST_OK)},
			'{command_item(CMD_IF_COND, 32'h0000_01AA, 1'b0, 13'd3), NO_NOTE},
			'{rx_item(R1_READY, 1'b0), NO_NOTE},
			'{rx_item(IDLE_BYTE, 1'b1), NO_NOTE},
			'{rx_item(8'h80, 1'b0), NO_NOTE},
			'{rx_item(8'h5A, 1'b0), status_note(ST_OK)},
			'{command_item(8'd63, 32'hFFFF_FFFF, 1'b1, 13'd0), NO_NOTE},
			'{rx_item(R1_READY, 1'b0), NO_NOTE},
			'{rx_item(TOKEN_START, 1'b0), NO_NOTE},
			'{rx_item(8'h12, 1'b1), NO_NOTE},
			'{rx_item(8'h34, 1'b0), NO_NOTE},
			'{rx_item(8'hFF, 1'b0), status_note(ST_OK)},
			'{command_item(CMD_READ_BLOCK, 32'h8000_0001, 1'b1, 13'd1), NO_NOTE},
			'{rx_item(R1_READY, 1'b0), NO_NOTE},
			'{rx_item(8'h3C, 1'b0), NO_NOTE},
			'{rx_item(8'h00, 1'b0), status_note(ST_TOKEN)},
			'{command_item(8'd55, 32'hA5A5_5A5A, 1'b0, 13'd2), NO_NOTE},
			'{rx_item(8'h42, 1'b0), NO_NOTE},
			'{command_item(8'd24, 32'h0, 1'b1, 13'd4096), NO_NOTE},
			'{rx_item(8'h05, 1'b0), NO_NOTE},
			'{rx_item(8'hC3, 1'b0), status_note(ST_RESP)},
			'{command_item(8'd1, 32'h0, 1'b0, 13'h1FFF), NO_NOTE},
			'{rx_item(8'h80, 1'b1), NO_NOTE},
			'{rx_item(8'h7E, 1'b0), status_note(ST_LINK)}
		};
		settings = '{
			'{17'd2, 17'd3},
			'{17'd0, 17'h1FFFF},
			'{17'h1FFFF, 17'd0},
			'{17'd1, 17'd2},
			'{17'd4, 17'd65536}
		};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i])
			send(directed[i].it, directed[i].note);
		settle();
		foreach (settings[s]) begin
			set_limits(settings[s]);
			random_items = 0;
			while (random_items < PHASE_ITEMS) begin
				in_idle = ($urandom_range(0, 2) != 0);
				out_idle = ($urandom_range(0, 2) != 0);
				random_transfer(1'b0);
			end
			settle();
		end
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
